// ----- rtl/sfg_pkg.sv -----
`timescale 1ns / 1ps
// sfg_pkg: widths, codes and the quarter-wave cosine table of the color fade generator
// used by every module in rtl/; depends on nothing

package sfg_pkg;

  localparam int PHASE_BITS          = 16;
  localparam int QUARTER_TABLE_DEPTH = 256;

  localparam int TIME_W     = 48;
  localparam int COLOR_W    = 32;
  localparam int PERIOD_W   = 16;
  localparam int STEP_W     = 32;
  localparam int LEVEL_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int COS_ROM_W = 15;
  localparam int COS_W     = 16;
  localparam int IDX_W     = $clog2(QUARTER_TABLE_DEPTH + 1);
  localparam int ITER_MAX  = (PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W;
  localparam int CNT_W     = $clog2(ITER_MAX);

  localparam logic [TIME_W-1:0] NS_PER_SEC = TIME_W'(64'd1000000000);
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = CFG_IDX_W'(3);

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK          = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_PERIOD_ZERO = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_STEP_ZERO   = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STAT_STEP_BIG    = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] STAT_ENDPOINTS   = STATUS_W'(4);

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              ge;
  } alu_rsp_t;

  typedef logic [COS_ROM_W-1:0] cos_rom_t [0:QUARTER_TABLE_DEPTH];

  // exact quotient by shift and subtract, used only while building the table
  function automatic longint unsigned shift_sub_div(input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q30 taylor series per entry, rounded to q15; evaluated at elaboration only
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint unsigned x;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    longint unsigned c;
    longint unsigned q;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x    = (HALFPI_Q30 * longint'(k)) / QUARTER_TABLE_DEPTH;
      pos  = 64'd1 << 30;
      neg  = 64'd0;
      term = 64'd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = shift_sub_div(term, longint'((2 * n - 1) * (2 * n)));
        if (n % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      c = (pos > neg) ? pos - neg : 64'd0;
      q = (c + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      rom[k] = COS_ROM_W'(q);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- rtl/sfg_alu.sv -----
`timescale 1ns / 1ps
// sfg_alu: the one 48-bit add / subtract-compare unit shared by the arithmetic steps of the sequencer
// depends on sfg_pkg

module sfg_alu import sfg_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TIME_W:0] total;

  // subtract as a + ~b + 1; carry out means a >= b
  assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + (TIME_W + 1)'(req.sub);

  assign rsp.sum = total[TIME_W-1:0];
  assign rsp.ge  = total[TIME_W];

endmodule

// ----- rtl/sfg_level.sv -----
`timescale 1ns / 1ps
// sfg_level: one channel level per cycle while lvl_en is high, mid - amp*cos
// depends on sfg_pkg; keeps the four level registers

module sfg_level import sfg_pkg::*; (
  input  logic                           clk,
  input  logic                           lvl_en,
  input  logic [CH_W-1:0]                lvl_ch,
  input  logic [COLOR_W-1:0]             start_color,
  input  logic [COLOR_W-1:0]             end_color,
  input  logic signed [COS_W-1:0]        cos_val,
  output logic [NUM_CH-1:0][LEVEL_W-1:0] levels
);

  logic [NUM_CH-1:0][LEVEL_W-1:0] s_bytes;
  logic [NUM_CH-1:0][LEVEL_W-1:0] e_bytes;
  logic [NUM_CH-1:0][LEVEL_W-1:0] lvl_r;
  logic [LEVEL_W-1:0]             s_val;
  logic [LEVEL_W-1:0]             e_val;
  logic [LEVEL_W:0]               sum;
  logic signed [LEVEL_W:0]        diff;
  logic signed [LEVEL_W:0]        amp_w;
  logic signed [LEVEL_W-1:0]      amp;
  logic signed [LEVEL_W+COS_W-1:0] prod;
  logic signed [LEVEL_W+COS_W:0]  v;
  logic [LEVEL_W:0]               whole;
  logic [LEVEL_W-1:0]             level;

  assign s_bytes = start_color;
  assign e_bytes = end_color;
  assign s_val   = s_bytes[lvl_ch];
  assign e_val   = e_bytes[lvl_ch];

  assign sum  = {1'b0, s_val} + {1'b0, e_val};
  assign diff = signed'({1'b0, e_val}) - signed'({1'b0, s_val});
  // halve toward zero
  assign amp_w = (diff + signed'((LEVEL_W + 1)'(diff[LEVEL_W]))) >>> 1;
  assign amp   = amp_w[LEVEL_W-1:0];
  assign prod  = amp * cos_val;
  assign v     = signed'({2'b00, sum[LEVEL_W:1], 15'd0}) - {prod[LEVEL_W+COS_W-1], prod};
  assign whole = v[LEVEL_W+15:15];

  always_comb begin
    if (v[LEVEL_W+COS_W]) begin
      level = '0;
    end else if (whole[LEVEL_W]) begin
      level = '1;
    end else begin
      level = whole[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_en) begin
      lvl_r[lvl_ch] <= level;
    end
  end

  assign levels = lvl_r;

endmodule

// ----- rtl/sine_color_fade_generator.sv -----
`timescale 1ns / 1ps
// sine_color_fade_generator: top level, registers, sequencer, phase divider and cosine lookup
// depends on sfg_pkg, sfg_alu, sfg_level
//
//   channel | ports                               | direction
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata     | in, write only
//   in      | in_valid, in_stall, in_restart      | in, one item per sample
//   out     | out_valid, out_stall, levels, flags | out, one result per item
//
// an ok item goes through 16 shift-add steps for the period in ns, 1 check, 1 wrap,
// PHASE_BITS divide steps, 1 lookup, 4 channels, 2 for the time update and 1 to load
// the output; an error item goes from the check to the load; arithmetic steps share one adder
// in_stall is high while an item is in work; the next item is taken while a result waits
// synchronous active-low reset clears config, elapsed time and handshake state

module sine_color_fade_generator import sfg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_red,
  output logic [LEVEL_W-1:0]    out_green,
  output logic [LEVEL_W-1:0]    out_blue,
  output logic [LEVEL_W-1:0]    out_brightness,
  output logic [STEP_W-1:0]     out_hold_ns,
  output logic                  out_last_of_cycle,
  output logic [STATUS_W-1:0]   out_status
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULP, ST_CHECK, ST_WRAP, ST_DIV, ST_LOOK, ST_CHAN, ST_ADDS, ST_CMPS, ST_FIN
  } state_t;

  state_t state_r;

  logic [COLOR_W-1:0]  start_color_r;
  logic [COLOR_W-1:0]  end_color_r;
  logic [PERIOD_W-1:0] period_s_r;
  logic [STEP_W-1:0]   step_r;

  logic [TIME_W-1:0]     elapsed_r;
  logic [TIME_W-1:0]     period_ns_r;
  logic [PERIOD_W-1:0]   pmul_sh_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TIME_W-1:0]     rem_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic signed [COS_W-1:0] cos_r;
  logic [TIME_W-1:0]     next_r;
  logic [STATUS_W-1:0]   status_r;
  logic                  last_r;

  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_red_r;
  logic [LEVEL_W-1:0]    out_green_r;
  logic [LEVEL_W-1:0]    out_blue_r;
  logic [LEVEL_W-1:0]    out_bright_r;
  logic [STEP_W-1:0]     out_hold_r;
  logic                  out_last_r;
  logic [STATUS_W-1:0]   out_status_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [NUM_CH-1:0][LEVEL_W-1:0] s_bytes;
  logic [NUM_CH-1:0][LEVEL_W-1:0] e_bytes;
  logic [NUM_CH-1:0][LEVEL_W-1:0] levels;
  logic                           ends_equal;
  logic [STATUS_W-1:0]            status_nxt;

  logic [PHASE_BITS-3:0]          frac;
  logic [PHASE_BITS-2+IDX_W-1:0]  idx_prod;
  logic [IDX_W-1:0]               idx;
  logic [IDX_W-1:0]               rom_idx;
  logic [COS_ROM_W-1:0]           rom_val;
  logic signed [COS_W-1:0]        cos_mag;
  logic signed [COS_W-1:0]        cos_nxt;
  logic                           load_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= '0;
      end_color_r   <= '0;
      period_s_r    <= '0;
      step_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START:  start_color_r <= cfg_wdata[COLOR_W-1:0];
        CFG_END:    end_color_r   <= cfg_wdata[COLOR_W-1:0];
        CFG_PERIOD: period_s_r    <= cfg_wdata[PERIOD_W-1:0];
        CFG_STEP:   step_r        <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared adder
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state_r)
      ST_MULP: begin
        alu_req.a = {period_ns_r[TIME_W-2:0], 1'b0};
        alu_req.b = pmul_sh_r[PERIOD_W-1] ? NS_PER_SEC : '0;
      end
      ST_CHECK: begin
        alu_req.a   = TIME_W'(step_r);
        alu_req.b   = period_ns_r;
        alu_req.sub = 1'b1;
      end
      ST_WRAP: begin
        alu_req.a   = elapsed_r;
        alu_req.b   = period_ns_r;
        alu_req.sub = 1'b1;
      end
      ST_DIV: begin
        alu_req.a   = {rem_r[TIME_W-2:0], 1'b0};
        alu_req.b   = period_ns_r;
        alu_req.sub = 1'b1;
      end
      ST_ADDS: begin
        alu_req.a = elapsed_r;
        alu_req.b = TIME_W'(step_r);
      end
      ST_CMPS: begin
        alu_req.a   = next_r;
        alu_req.b   = period_ns_r;
        alu_req.sub = 1'b1;
      end
      default: ;
    endcase
  end

  sfg_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // error checks in priority order
  assign s_bytes = start_color_r;
  assign e_bytes = end_color_r;

  always_comb begin
    ends_equal = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (s_bytes[i] == e_bytes[i]) ends_equal = 1'b1;
    end
    if (period_s_r == '0) begin
      status_nxt = STAT_PERIOD_ZERO;
    end else if (step_r == '0) begin
      status_nxt = STAT_STEP_ZERO;
    end else if (alu_rsp.ge) begin
      status_nxt = STAT_STEP_BIG;
    end else if (ends_equal) begin
      status_nxt = STAT_ENDPOINTS;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  // quarter-wave lookup: odd quadrants mirror the index, middle two negate
  assign frac     = phase_r[PHASE_BITS-3:0];
  assign idx_prod = (PHASE_BITS - 2 + IDX_W)'(frac) *
                    (PHASE_BITS - 2 + IDX_W)'(QUARTER_TABLE_DEPTH);
  assign idx      = idx_prod[PHASE_BITS-2+IDX_W-1:PHASE_BITS-2];
  assign rom_idx  = phase_r[PHASE_BITS-2] ? IDX_W'(QUARTER_TABLE_DEPTH) - idx : idx;
  assign rom_val  = COS_ROM[rom_idx];
  assign cos_mag  = signed'({1'b0, rom_val});
  assign cos_nxt  = (phase_r[PHASE_BITS-1] ^ phase_r[PHASE_BITS-2]) ? -cos_mag : cos_mag;

  sfg_level u_level (
    .clk         (clk),
    .lvl_en      (state_r == ST_CHAN),
    .lvl_ch      (cnt_r[CH_W-1:0]),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .cos_val     (cos_r),
    .levels      (levels)
  );

  assign load_out = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_restart) elapsed_r <= '0;
            period_ns_r <= '0;
            pmul_sh_r   <= period_s_r;
            cnt_r       <= CNT_W'(PERIOD_W - 1);
            state_r     <= ST_MULP;
          end
        end
        ST_MULP: begin
          // period in ns, msb-first shift and add
          period_ns_r <= alu_rsp.sum;
          pmul_sh_r   <= {pmul_sh_r[PERIOD_W-2:0], 1'b0};
          if (cnt_r == '0) state_r <= ST_CHECK;
          else cnt_r <= cnt_r - 1'b1;
        end
        ST_CHECK: begin
          status_r <= status_nxt;
          last_r   <= 1'b0;
          state_r  <= (status_nxt != STAT_OK) ? ST_FIN : ST_WRAP;
        end
        ST_WRAP: begin
          if (alu_rsp.ge) begin
            elapsed_r <= '0;
            rem_r     <= '0;
          end else begin
            rem_r <= elapsed_r;
          end
          phase_r <= '0;
          cnt_r   <= CNT_W'(PHASE_BITS - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one phase bit per cycle
          rem_r   <= alu_rsp.ge ? alu_rsp.sum : alu_req.a;
          phase_r <= {phase_r[PHASE_BITS-2:0], alu_rsp.ge};
          if (cnt_r == '0) state_r <= ST_LOOK;
          else cnt_r <= cnt_r - 1'b1;
        end
        ST_LOOK: begin
          cos_r   <= cos_nxt;
          cnt_r   <= '0;
          state_r <= ST_CHAN;
        end
        ST_CHAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[CH_W-1:0] == CH_W'(NUM_CH - 1)) state_r <= ST_ADDS;
        end
        ST_ADDS: begin
          next_r  <= alu_rsp.sum;
          state_r <= ST_CMPS;
        end
        ST_CMPS: begin
          if (alu_rsp.ge) begin
            last_r    <= 1'b1;
            elapsed_r <= '0;
          end else begin
            elapsed_r <= next_r;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hold_r   <= step_r;
      out_status_r <= status_r;
      out_last_r   <= last_r;
      if (status_r == STAT_OK) begin
        out_red_r    <= levels[0];
        out_green_r  <= levels[1];
        out_blue_r   <= levels[2];
        out_bright_r <= levels[3];
      end else begin
        out_red_r    <= '0;
        out_green_r  <= '0;
        out_blue_r   <= '0;
        out_bright_r <= '0;
      end
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_brightness    = out_bright_r;
  assign out_hold_ns       = out_hold_r;
  assign out_last_of_cycle = out_last_r;
  assign out_status        = out_status_r;

endmodule

// ----- rtl/sfg_checker.sv -----
`timescale 1ns / 1ps
// sfg_checker: port-level assertions for the color fade generator, bound to the top level
// depends on sfg_pkg and sine_color_fade_generator

module sfg_port_props import sfg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LEVEL_W-1:0]    out_red,
  input logic [LEVEL_W-1:0]    out_green,
  input logic [LEVEL_W-1:0]    out_blue,
  input logic [LEVEL_W-1:0]    out_brightness,
  input logic [STEP_W-1:0]     out_hold_ns,
  input logic                  out_last_of_cycle,
  input logic [STATUS_W-1:0]   out_status
);

  // an accepted item leaves the block busy right after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("in_stall low right after an item was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_brightness) && $stable(out_status) &&
      $stable(out_last_of_cycle) && $stable(out_hold_ns))
    else $error("stalled result changed");

  // errors zero the colors and the wrap flag
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |->
      out_red == '0 && out_green == '0 && out_blue == '0 && out_brightness == '0 &&
      !out_last_of_cycle)
    else $error("error result with nonzero levels");

  // a zero step is always reported, so an ok item has a nonzero hold time
  a_ok_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_OK) |-> out_hold_ns != '0)
    else $error("ok result with zero hold time");

endmodule

bind sine_color_fade_generator sfg_port_props u_sfg_port_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_red           (out_red),
  .out_green         (out_green),
  .out_blue          (out_blue),
  .out_brightness    (out_brightness),
  .out_hold_ns       (out_hold_ns),
  .out_last_of_cycle (out_last_of_cycle),
  .out_status        (out_status)
);

// ----- tb/sfg_checker.sv -----
`timescale 1ns / 1ps
// sfg_checker: watches the config port and both channels of sine_color_fade_generator,
// predicts each color sample and compares it field by field; depends on sfg_pkg

module sfg_checker import sfg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_restart,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [LEVEL_W-1:0]    out_red,
  input  logic [LEVEL_W-1:0]    out_green,
  input  logic [LEVEL_W-1:0]    out_blue,
  input  logic [LEVEL_W-1:0]    out_brightness,
  input  logic [STEP_W-1:0]     out_hold_ns,
  input  logic                  out_last_of_cycle,
  input  logic [STATUS_W-1:0]   out_status,
  output int                    outstanding,
  output int                    mismatches
);

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned NS_IN_SECOND     = 64'd1000000000;

  typedef struct packed {
    logic [NUM_CH-1:0][LEVEL_W-1:0] level;
    logic [STEP_W-1:0]              hold;
    logic                           last;
    logic [STATUS_W-1:0]            status;
  } fade_sample_t;

  logic [COLOR_W-1:0]  start_color_q;
  logic [COLOR_W-1:0]  end_color_q;
  logic [PERIOD_W-1:0] period_s_q;
  logic [STEP_W-1:0]   step_ns_q;
  logic [TIME_W-1:0]   elapsed_q;
  int                  cos_table [0:QUARTER_TABLE_DEPTH];
  fade_sample_t        sample_q [$];
  int                  fail_tally = 0;

  // quarter-wave cosine in q1.15 from a q30 taylor series
  initial begin
    longint unsigned x, pos, neg, term, c, q;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x    = (QUARTER_TURN_Q30 * 64'(k)) / 64'(QUARTER_TABLE_DEPTH);
      pos  = 64'd1 << 30;
      neg  = 64'd0;
      term = 64'd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      c = (pos > neg) ? pos - neg : 64'd0;
      q = (c + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      cos_table[k] = int'(q);
    end
  end

  function automatic fade_sample_t predict_sample(input logic restart);
    fade_sample_t        r;
    longint unsigned     period_ns, rem, next_t;
    logic [PHASE_BITS-1:0] phase;
    logic [1:0]          quad;
    int                  idx, cosv, s, e, mid, amp, v;
    r = '0;
    r.status = STAT_OK;
    r.hold = step_ns_q;
    period_ns = 64'(period_s_q) * NS_IN_SECOND;
    if (restart) elapsed_q = '0;
    if (period_s_q == 0) r.status = STAT_PERIOD_ZERO;
    else if (step_ns_q == 0) r.status = STAT_STEP_ZERO;
    else if (64'(step_ns_q) >= period_ns) r.status = STAT_STEP_BIG;
    else begin
      for (int ch = 0; ch < NUM_CH; ch++)
        if (start_color_q[8*ch +: 8] == end_color_q[8*ch +: 8]) r.status = STAT_ENDPOINTS;
    end
    if (r.status != STAT_OK) return r;

    // registers may have moved the period below the elapsed time
    if (64'(elapsed_q) >= period_ns) elapsed_q = '0;
    rem = 64'(elapsed_q);
    phase = '0;
    for (int i = 0; i < PHASE_BITS; i++) begin
      rem = rem << 1;
      phase = {phase[PHASE_BITS-2:0], 1'b0};
      if (rem >= period_ns) begin
        rem -= period_ns;
        phase[0] = 1'b1;
      end
    end
    quad = phase[PHASE_BITS-1 -: 2];
    idx = (int'(phase[PHASE_BITS-3:0]) * QUARTER_TABLE_DEPTH) >> (PHASE_BITS - 2);
    if (idx >= QUARTER_TABLE_DEPTH) idx = QUARTER_TABLE_DEPTH - 1;
    case (quad)
      2'd0: cosv = cos_table[idx];
      2'd1: cosv = -cos_table[QUARTER_TABLE_DEPTH - idx];
      2'd2: cosv = -cos_table[idx];
      default: cosv = cos_table[QUARTER_TABLE_DEPTH - idx];
    endcase

    for (int ch = 0; ch < NUM_CH; ch++) begin
      s = int'(start_color_q[8*ch +: 8]);
      e = int'(end_color_q[8*ch +: 8]);
      mid = (s + e) / 2;
      amp = (e - s) / 2;
      v = mid * 32768 - amp * cosv;
      if (v < 0) v = 0;
      v = v >>> 15;
      r.level[ch] = (v > 255) ? 8'd255 : v[7:0];
    end

    next_t = 64'(elapsed_q) + 64'(step_ns_q);
    if (next_t >= period_ns) begin
      r.last = 1'b1;
      elapsed_q = '0;
    end else begin
      elapsed_q = next_t[TIME_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    fade_sample_t want;
    if (!rst_n) begin
      start_color_q = '0;
      end_color_q   = '0;
      period_s_q    = '0;
      step_ns_q     = '0;
      elapsed_q     = '0;
      sample_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START:  start_color_q = cfg_wdata[COLOR_W-1:0];
          CFG_END:    end_color_q   = cfg_wdata[COLOR_W-1:0];
          CFG_PERIOD: period_s_q    = cfg_wdata[PERIOD_W-1:0];
          CFG_STEP:   step_ns_q     = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      // results first, so a sample taken on this edge is never matched to it
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $error("result with no item waiting");
          fail_tally++;
        end else begin
          want = sample_q.pop_front();
          check_field("red", want.level[0], out_red);
          check_field("green", want.level[1], out_green);
          check_field("blue", want.level[2], out_blue);
          check_field("brightness", want.level[3], out_brightness);
          check_field("hold_ns", want.hold, out_hold_ns);
          check_field("last_of_cycle", want.last, out_last_of_cycle);
          check_field("status", want.status, out_status);
        end
      end
      if (in_valid && !in_stall) sample_q.push_back(predict_sample(in_restart));
    end
    outstanding <= sample_q.size();
    mismatches  <= fail_tally;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for sine_color_fade_generator; directed fades and error cases,
// then random fades with bursty items and receiver stalls; depends on sfg_pkg, sfg_checker

module tb;
  import sfg_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 1500000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    out_red;
  logic [LEVEL_W-1:0]    out_green;
  logic [LEVEL_W-1:0]    out_blue;
  logic [LEVEL_W-1:0]    out_brightness;
  logic [STEP_W-1:0]     out_hold_ns;
  logic                  out_last_of_cycle;
  logic [STATUS_W-1:0]   out_status;

  int outstanding;
  int fail_count;
  int burst_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  sine_color_fade_generator u_top (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_restart,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_brightness,
    .out_hold_ns, .out_last_of_cycle, .out_status
  );

  sfg_checker u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_restart,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_brightness,
    .out_hold_ns, .out_last_of_cycle, .out_status,
    .outstanding, .mismatches(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sine_color_fade_generator: FAILED **");
    $finish;
  end

  // receiver: stretches of no stall, random stall, heavy stall and a slow square wave
  initial begin
    int stall_mode, stretch;
    out_stall = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stretch = $urandom_range(20, 300);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= k[4];
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_fade(input logic [31:0] s, input logic [31:0] e,
                          input logic [15:0] p, input logic [31:0] st);
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    // upper bits of a period write are ignored by the block
    write_reg(CFG_PERIOD, {16'($urandom), p});
    write_reg(CFG_STEP, st);
  endtask

  // sends a run of items in bursts, then waits until every sample is back
  task automatic run_phase(input int count, input int restart_pct);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          in_restart <= 1'($urandom_range(0, 1));
          repeat (gap - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_restart <= ($urandom_range(0, 99) < restart_pct);
      do @(posedge clk); while (in_stall);
      burst_left--;
      items_sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    logic [31:0] s, e, st;
    logic [15:0] p;
    longint unsigned span;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers still at reset: period is zero
    run_phase(2, 50);
    set_fade(32'h00000000, 32'hFFFFFFFF, 16'd1, 32'd0);
    run_phase(1, 0);
    // step equal to the period
    set_fade(32'h00000000, 32'hFFFFFFFF, 16'd1, 32'd1000000000);
    run_phase(1, 0);
    set_fade(32'h00000000, 32'hFFFFFFFF, 16'd0, 32'd1000);
    run_phase(1, 0);
    // largest 32-bit step, still below the period
    set_fade(32'h00000000, 32'hFFFFFFFF, 16'd5, 32'hFFFFFFFF);
    run_phase(2, 0);
    // equal endpoints on each channel in turn
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e = ~32'h12345678;
      e[8*ch +: 8] = 8'(32'h12345678 >> (8 * ch));
      set_fade(32'h12345678, e, 16'd5, 32'hFFFFFFFF);
      run_phase(1, 0);
    end
    // full swing, four samples per period, both directions
    set_fade(32'h00000000, 32'hFFFFFFFF, 16'd1, 32'd250000000);
    run_phase(5, 0);
    set_fade(32'hFFFFFFFF, 32'h00000000, 16'd1, 32'd250000000);
    run_phase(3, 50);
    // shrink the period below the elapsed time
    set_fade(32'h80017F02, 32'h7F0280FE, 16'd10, 32'd3000000000);
    run_phase(3, 0);
    set_fade(32'h80017F02, 32'h7F0280FE, 16'd1, 32'd100000000);
    run_phase(1, 0);
    // longest period, smallest step, tiny amplitudes
    set_fade(32'h01010101, 32'h02000302, 16'd65535, 32'd1);
    run_phase(2, 0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      s = $urandom;
      e = $urandom;
      if (kind == 0) begin
        p = 16'($urandom);
        st = $urandom;
      end else if (kind == 1) begin
        p = 16'($urandom_range(1, 4));
        st = $urandom;
        case ($urandom_range(0, 2))
          0: p = '0;
          1: st = '0;
          default: st = $urandom_range(32'(64'(p) * 64'd1000000000), 32'hFFFFFFFF);
        endcase
      end else begin
        if ($urandom_range(0, 5) == 0) e = s + 32'h01010101;
        for (int ch = 0; ch < NUM_CH; ch++)
          if (e[8*ch +: 8] == s[8*ch +: 8]) e[8*ch +: 8] = ~s[8*ch +: 8];
        if ($urandom_range(0, 7) == 0) begin
          p = 16'($urandom_range(5, 65535));
          st = $urandom | 32'd1;
        end else begin
          p = 16'($urandom_range(1, 4));
          span = (64'(p) * 64'd1000000000) / 64'($urandom_range(2, 40));
          st = 32'(span) - 32'($urandom_range(0, 999));
        end
      end
      set_fade(s, e, p, st);
      run_phase($urandom_range(15, 60), ($urandom_range(0, 1) == 0) ? 5 : 30);
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sine_color_fade_generator: PASSED **");
    end else begin
      $display("** sine_color_fade_generator: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sine_color_fade_generator.f -----
rtl/sfg_pkg.sv
rtl/sfg_alu.sv
rtl/sfg_level.sv
rtl/sine_color_fade_generator.sv
rtl/sfg_checker.sv
tb/sfg_checker.sv
tb/tb.sv
